### rtl/core/wrf_pkg.sv
// ----------------------------------------------------------------------------
// wrf_pkg: shared types and constants
// Widths, selector codes, controller states and command/status structs.
// ----------------------------------------------------------------------------
package wrf_pkg;

    localparam int MAX_CANDIDATES_DEF = 32;
    localparam int TABLE_DEPTH        = 64;
    localparam int IDX_W              = 6;
    localparam int CNT_W              = 7;
    localparam int KEY_W              = 48;
    localparam int SCORE_W            = 32;
    localparam int RANK_W             = 6;
    localparam int CFG_W              = 24;
    localparam int CFG_IDX_W          = 2;
    localparam int DIV_N_W            = 32;
    localparam int DIV_D_W            = 17;

    localparam logic [1:0] FUNC_ONE    = 2'd0;
    localparam logic [1:0] FUNC_TWO    = 2'd1;
    localparam logic [1:0] FUNC_FINISH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_RANK_OFFSET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ONE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_TWO   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESULT_LIMIT = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DIVIDE,
        ST_UPDATE,
        ST_SELECT,
        ST_PICK,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    typedef struct packed {
        logic       take_item;   // latch input word, start search
        logic       search_step; // read next entry / compare
        logic       div_start;
        logic       do_update;   // write entry
        logic       sel_start;   // begin scan for best unused entry
        logic       sel_step;
        logic       pick;        // mark best used, count it as emitted
        logic       load_empty;
        logic       clear;       // drop table after finish
    } cmd_t;

    typedef struct packed {
        logic       item_ok;     // rank counter not exhausted
        logic       search_done;
        logic       found;
        logic       table_full;
        logic       div_done;
        logic       sel_done;
        logic       emit_last;
        logic       none;        // entry count zero
    } status_t;

endpackage

### rtl/core/wrf_if.sv
// ----------------------------------------------------------------------------
// wrf_in_if / wrf_out_if: valid/ready channels
// Input words and result words of the fusion block.
// ----------------------------------------------------------------------------
interface wrf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] block_number;
    logic [15:0] offset_number;
    modport source (output valid, func, block_number, offset_number, input ready);
    modport sink   (input valid, func, block_number, offset_number, output ready);
endinterface

interface wrf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_block;
    logic [15:0] out_offset;
    logic [31:0] fused_score;
    logic [5:0]  rank_in_one;
    logic [5:0]  rank_in_two;
    logic        empty_marker;
    logic        last_result;
    modport source (output valid, out_block, out_offset, fused_score, rank_in_one,
                    rank_in_two, empty_marker, last_result, input ready);
    modport sink   (input valid, out_block, out_offset, fused_score, rank_in_one,
                    rank_in_two, empty_marker, last_result, output ready);
endinterface

### rtl/core/weighted_rank_fusion_topk.sv
// Per list item: accept, then table search, serial divide and entry update.
// Finish: per emitted result a table scan, a pick and an emit, plus output stalls.
// Items are taken one at a time: a new one is accepted only in idle, after the last is done.
// Reset: asynchronous active low; clears counts, ranks, registers to defaults.
// Table memories are not cleared; entries above the count are never read.
// ----------------------------------------------------------------------------
// weighted_rank_fusion_topk: two-list weighted reciprocal rank fusion
// Accumulates fused scores per row identifier and emits them ranked.
// ----------------------------------------------------------------------------
module weighted_rank_fusion_topk
    import wrf_pkg::*;
#(
    parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    wrf_in_if.sink               in_ch,
    wrf_out_if.source            out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);
    logic [15:0] rank_offset_reg;
    logic [23:0] weight_one_reg, weight_two_reg;
    logic [6:0]  result_limit_reg;
    cmd_t        cmd;
    status_t     sts;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_offset_reg  <= 16'd60;
            weight_one_reg   <= 24'd32768;
            weight_two_reg   <= 24'd32768;
            result_limit_reg <= 7'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RANK_OFFSET:  rank_offset_reg  <= cfg_data[15:0];
                REG_WEIGHT_ONE:   weight_one_reg   <= cfg_data;
                REG_WEIGHT_TWO:   weight_two_reg   <= cfg_data;
                REG_RESULT_LIMIT: result_limit_reg <= cfg_data[6:0];
                default:          ;
            endcase
        end
    end

    wrf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_func   (in_ch.func),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_last  (out_ch.last_result),
        .sts       (sts),
        .cmd       (cmd)
    );

    wrf_datapath #(.MAX_CANDIDATES(MAX_CANDIDATES)) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_func      (in_ch.func),
        .in_block     (in_ch.block_number),
        .in_offset    (in_ch.offset_number),
        .rank_offset  (rank_offset_reg),
        .weight_one   (weight_one_reg),
        .weight_two   (weight_two_reg),
        .result_limit (result_limit_reg),
        .o_block      (out_ch.out_block),
        .o_offset     (out_ch.out_offset),
        .o_score      (out_ch.fused_score),
        .o_rank_one   (out_ch.rank_in_one),
        .o_rank_two   (out_ch.rank_in_two),
        .o_empty      (out_ch.empty_marker)
    );
endmodule

### rtl/core/wrf_div.sv
// ----------------------------------------------------------------------------
// wrf_div: restoring divider
// One quotient bit per cycle, unsigned 32 by 17 bit.
// ----------------------------------------------------------------------------
module wrf_div
    import wrf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] numer,
    input  logic [DIV_D_W-1:0] denom,
    output logic               done,
    output logic [DIV_N_W-1:0] quot
);
    localparam int STEP_W = $clog2(DIV_N_W + 1);

    logic [DIV_N_W-1:0] q_reg, q_next;
    logic [DIV_D_W:0]   r_reg, r_next;
    logic [DIV_D_W-1:0] d_reg, d_next;
    logic [STEP_W-1:0]  n_reg, n_next;
    logic               busy_reg, busy_next;
    logic [DIV_D_W:0]   trial;

    // shift in one numerator bit, subtract if it fits
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        n_next    = n_reg;
        busy_next = busy_reg;
        trial     = {r_reg[DIV_D_W-1:0], q_reg[DIV_N_W-1]};
        if (start)
        begin
            q_next    = numer;
            r_next    = '0;
            d_next    = denom;
            n_next    = STEP_W'(DIV_N_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[DIV_N_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[DIV_N_W-2:0], 1'b0};
            end
            n_next = n_reg - 1'b1;
            if (n_reg == STEP_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            n_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            n_reg    <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = busy_reg && n_reg == STEP_W'(1);
    assign quot = q_next;
endmodule

### rtl/core/wrf_datapath.sv
// ----------------------------------------------------------------------------
// wrf_datapath: entry table, search, score update and selection scan
// Holds keys, ranks and scores in memories; finds the next best entry.
// ----------------------------------------------------------------------------
module wrf_datapath
    import wrf_pkg::*;
#(
    parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     sts,
    input  logic [1:0]  in_func,
    input  logic [31:0] in_block,
    input  logic [15:0] in_offset,
    input  logic [15:0] rank_offset,
    input  logic [23:0] weight_one,
    input  logic [23:0] weight_two,
    input  logic [6:0]  result_limit,
    output logic [31:0] o_block,
    output logic [15:0] o_offset,
    output logic [31:0] o_score,
    output logic [5:0]  o_rank_one,
    output logic [5:0]  o_rank_two,
    output logic        o_empty
);
    localparam logic [RANK_W-1:0] RANK_CAP = RANK_W'(MAX_CANDIDATES);

    logic [KEY_W-1:0]    key_mem   [TABLE_DEPTH];
    logic [2*RANK_W-1:0] rank_mem  [TABLE_DEPTH];
    logic [SCORE_W-1:0]  score_mem [TABLE_DEPTH];

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [RANK_W-1:0] nr1_reg, nr1_next, nr2_reg, nr2_next;
    logic              second_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic              found_reg, found_next;
    logic              rd_v_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [KEY_W-1:0]    rd_key_reg;
    logic [2*RANK_W-1:0] rd_rank_reg;
    logic [SCORE_W-1:0]  rd_score_reg;
    logic [RANK_W-1:0]   rank_reg;

    logic [TABLE_DEPTH-1:0] used_reg;
    logic               best_v_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [SCORE_W-1:0] best_score_reg;
    logic [RANK_W:0]    best_e1_reg, best_e2_reg;
    logic [CNT_W-1:0]   emitted_reg, emit_n;

    logic [DIV_N_W-1:0] div_q;
    logic               div_done;
    logic [RANK_W-1:0]  cur_cnt;
    logic [23:0]        weight;

    assign cur_cnt = (cmd.take_item ? (in_func == FUNC_TWO) : second_reg) ? nr2_reg : nr1_reg;
    assign weight  = second_reg ? weight_two : weight_one;

    wrf_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .numer ({weight, 8'd0}),
        .denom (DIV_D_W'(rank_offset) + DIV_D_W'(rank_reg)),
        .done  (div_done),
        .quot  (div_q)
    );

    function automatic logic [RANK_W:0] eff(input logic [RANK_W-1:0] r);
        eff = (r == '0) ? (RANK_W+1)'(TABLE_DEPTH) : {1'b0, r};
    endfunction

    // latch the word and walk the table
    always_comb
    begin
        ptr_next   = ptr_reg;
        slot_next  = slot_reg;
        found_next = found_reg;
        if (cmd.take_item || cmd.sel_start)
        begin
            ptr_next   = '0;
            found_next = 1'b0;
        end
        else if (cmd.search_step || cmd.sel_step)
        begin
            if (ptr_reg < count_reg)
                ptr_next = ptr_reg + 1'b1;
            if (cmd.search_step && rd_v_reg && rd_key_reg == key_reg && !found_reg)
            begin
                found_next = 1'b1;
                slot_next  = rd_idx_reg;
            end
        end
        if (cmd.div_start && !found_reg)
            slot_next = count_reg[IDX_W-1:0];
    end

    // one read per cycle, registered; rank is fixed when the word is taken
    always_ff @(posedge clk)
    begin
        rd_key_reg   <= key_mem[ptr_reg[IDX_W-1:0]];
        rd_rank_reg  <= rank_mem[ptr_reg[IDX_W-1:0]];
        rd_score_reg <= score_mem[ptr_reg[IDX_W-1:0]];
        rd_idx_reg   <= ptr_reg[IDX_W-1:0];
        ptr_reg      <= ptr_next;
        slot_reg     <= slot_next;
        found_reg    <= found_next;
        if (cmd.take_item)
        begin
            key_reg    <= {in_block, in_offset};
            second_reg <= (in_func == FUNC_TWO);
            rank_reg   <= cur_cnt + 1'b1;
        end
    end

    // write the updated entry: re-read of the slot is done by the search
    logic [SCORE_W-1:0]  old_score;
    logic [2*RANK_W-1:0] old_rank;
    logic [SCORE_W-1:0]  hold_score_reg;
    logic [2*RANK_W-1:0] hold_rank_reg;
    logic [SCORE_W:0]    sum;
    always_ff @(posedge clk)
    begin
        if (cmd.search_step && rd_v_reg && rd_key_reg == key_reg && !found_reg)
        begin
            hold_score_reg <= rd_score_reg;
            hold_rank_reg  <= rd_rank_reg;
        end
    end
    assign old_score = found_reg ? hold_score_reg : '0;
    assign old_rank  = found_reg ? hold_rank_reg : '0;
    assign sum       = {1'b0, old_score} + {1'b0, div_q};

    always_ff @(posedge clk)
    begin
        if (cmd.do_update)
        begin
            key_mem[slot_reg]   <= key_reg;
            score_mem[slot_reg] <= sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];
            rank_mem[slot_reg]  <= second_reg ? {rank_reg, old_rank[RANK_W-1:0]}
                                              : {old_rank[2*RANK_W-1:RANK_W], rank_reg};
        end
    end

    // counters: entry count and per-list ranks
    always_comb
    begin
        count_next = count_reg;
        nr1_next   = nr1_reg;
        nr2_next   = nr2_reg;
        if (cmd.clear)
        begin
            count_next = '0;
            nr1_next   = '0;
            nr2_next   = '0;
        end
        else if (cmd.do_update)
        begin
            if (!found_reg)
                count_next = count_reg + 1'b1;
            if (second_reg)
                nr2_next = rank_reg;
            else
                nr1_next = rank_reg;
        end
    end

    // selection scan: best entry not yet emitted
    logic rd_better;
    always_comb
    begin
        rd_better = 1'b0;
        if (!best_v_reg)
            rd_better = 1'b1;
        else if (rd_score_reg != best_score_reg)
            rd_better = rd_score_reg > best_score_reg;
        else if (eff(rd_rank_reg[RANK_W-1:0]) != best_e1_reg)
            rd_better = eff(rd_rank_reg[RANK_W-1:0]) < best_e1_reg;
        else
            rd_better = eff(rd_rank_reg[2*RANK_W-1:RANK_W]) < best_e2_reg;
    end

    assign emit_n = (result_limit != '0 && result_limit < count_reg) ? result_limit : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            nr1_reg     <= '0;
            nr2_reg     <= '0;
            rd_v_reg    <= 1'b0;
            used_reg    <= '0;
            best_v_reg  <= 1'b0;
            emitted_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            nr1_reg   <= nr1_next;
            nr2_reg   <= nr2_next;
            rd_v_reg  <= (cmd.search_step || cmd.sel_step) && ptr_reg < count_reg;
            if (cmd.sel_start)
                best_v_reg <= 1'b0;
            else if (cmd.sel_step && rd_v_reg && !used_reg[rd_idx_reg] && rd_better)
                best_v_reg <= 1'b1;
            if (cmd.pick)
            begin
                used_reg[best_idx_reg] <= 1'b1;
                emitted_reg            <= emitted_reg + 1'b1;
            end
            if (cmd.clear)
            begin
                used_reg    <= '0;
                emitted_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sel_step && rd_v_reg && !used_reg[rd_idx_reg] && rd_better)
        begin
            best_idx_reg   <= rd_idx_reg;
            best_score_reg <= rd_score_reg;
            best_e1_reg    <= eff(rd_rank_reg[RANK_W-1:0]);
            best_e2_reg    <= eff(rd_rank_reg[2*RANK_W-1:RANK_W]);
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (cmd.load_empty)
        begin
            o_block    <= '0;
            o_offset   <= '0;
            o_score    <= '0;
            o_rank_one <= '0;
            o_rank_two <= '0;
            o_empty    <= 1'b1;
        end
        else if (cmd.sel_step && rd_v_reg && !used_reg[rd_idx_reg] && rd_better)
        begin
            o_block    <= rd_key_reg[KEY_W-1:16];
            o_offset   <= rd_key_reg[15:0];
            o_score    <= rd_score_reg;
            o_rank_one <= rd_rank_reg[RANK_W-1:0];
            o_rank_two <= rd_rank_reg[2*RANK_W-1:RANK_W];
            o_empty    <= 1'b0;
        end
    end

    assign sts.item_ok     = cur_cnt < RANK_CAP;
    assign sts.search_done = ptr_reg >= count_reg && !rd_v_reg;
    assign sts.found       = found_reg;
    assign sts.table_full  = count_reg >= CNT_W'(TABLE_DEPTH);
    assign sts.div_done    = div_done;
    assign sts.sel_done    = ptr_reg >= count_reg && !rd_v_reg;
    assign sts.emit_last   = emitted_reg + 1'b1 >= emit_n;
    assign sts.none        = count_reg == '0;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_update && !found_reg |-> count_reg < CNT_W'(TABLE_DEPTH))
        else $error("entry created in a full table");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pick |-> best_v_reg && !used_reg[best_idx_reg])
        else $error("picked entry invalid or already emitted");
    assert property (@(posedge clk) disable iff (!rst_n)
        nr1_reg <= RANK_CAP && nr2_reg <= RANK_CAP)
        else $error("rank counter beyond limit");
endmodule

### rtl/core/wrf_ctrl.sv
// ----------------------------------------------------------------------------
// wrf_ctrl: controller state machine
// Sequences search, divide and update per item, selection and emit on finish.
// ----------------------------------------------------------------------------
module wrf_ctrl
    import wrf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_func,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       out_last,
    input  status_t    sts,
    output cmd_t       cmd
);
    state_t state_reg, state_next;
    logic   last_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    if (in_func == FUNC_FINISH)
                        state_next = sts.none ? ST_EMPTY : ST_SELECT;
                    else if ((in_func == FUNC_ONE || in_func == FUNC_TWO) && sts.item_ok)
                        state_next = ST_SEARCH;
                end
            ST_SEARCH:
                if (sts.search_done)
                    state_next = (!sts.found && sts.table_full) ? ST_IDLE : ST_DIVIDE;
            ST_DIVIDE:
                if (sts.div_done)
                    state_next = ST_UPDATE;
            ST_UPDATE:
                state_next = ST_IDLE;
            ST_SELECT:
                if (sts.sel_done)
                    state_next = ST_PICK;
            ST_PICK:
                state_next = ST_EMIT;
            ST_EMIT:
                if (out_ready)
                    state_next = last_reg ? ST_IDLE : ST_SELECT;
            ST_EMPTY:
                if (out_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // commands
    logic div_go_reg;
    always_comb
    begin
        cmd         = '0;
        in_ready    = state_reg == ST_IDLE;
        out_valid   = state_reg == ST_EMIT || state_reg == ST_EMPTY;
        out_last    = state_reg == ST_EMPTY || last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.take_item  = in_valid;
                cmd.sel_start  = in_valid && in_func == FUNC_FINISH;
                cmd.load_empty = in_valid && in_func == FUNC_FINISH && sts.none;
            end
            ST_SEARCH: cmd.search_step = 1'b1;
            ST_DIVIDE: cmd.div_start   = div_go_reg;
            ST_UPDATE: cmd.do_update   = 1'b1;
            ST_SELECT: cmd.sel_step    = 1'b1;
            ST_PICK:   cmd.pick        = 1'b1;
            ST_EMIT:
            begin
                cmd.sel_start = out_ready;
                cmd.clear     = out_ready && last_reg;
            end
            ST_EMPTY:  cmd.clear = out_ready;
            default:   cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            last_reg   <= 1'b0;
            div_go_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            div_go_reg <= state_reg == ST_SEARCH && state_next == ST_DIVIDE;
            if (cmd.pick)
                last_reg <= sts.emit_last;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPDATE |=> state_reg == ST_IDLE)
        else $error("update not followed by idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken during emit");
endmodule
